// File: hdl/bhq_pkg.sv
package bhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // heap levels 0..LVL_CNT-1; the count and the level span share the same log
  localparam int LVL_CNT  = CNT_W;
  localparam int NCELL    = LVL_CNT - 1;
  localparam int LVL_W    = $clog2(LVL_CNT);
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int ROW_W    = (LVL_CNT > 2) ? LVL_CNT - 2 : 1;
  localparam int CHK_W    = CNT_W + 3;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t KEY_NONE = '1;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // operation token handed from one level to the next
  typedef struct packed {
    logic              vld;
    op_t               op;
    logic              shift;
    key_t              key;
    logic [ROW_W-1:0]  par_off;
    logic [POS_W-1:0]  par_pos;
    logic [CNT_W-1:0]  path;
    logic [LVL_W-1:0]  lv_left;
    logic [CNT_W-1:0]  lim;
  } tok_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic             half;
    key_t             data;
  } wr_t;

  typedef struct packed {
    logic             en;
    logic [LVL_W-1:0] lvl;
    logic [ROW_W-1:0] row;
    logic             half;
  } fetch_t;

  function automatic logic key_less(input key_t a, input key_t b);
    return a < b;
  endfunction

  function automatic logic [LVL_W-1:0] lead_one(input logic [CNT_W-1:0] v);
    logic [LVL_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) idx = LVL_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: hdl/bhq_ram.sv
module bhq_ram import bhq_pkg::*; #(
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic               clk,
  input  logic [1:0]         we,
  input  logic [AW-1:0]      waddr,
  input  key_t               wdata,
  input  logic [AW-1:0]      raddr,
  output logic [2*KEY_W-1:0] rdata
);

  logic [2*KEY_W-1:0] mem [DEPTH];
  logic [2*KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we[0]) mem[waddr][KEY_W-1:0] <= wdata;
    if (we[1]) mem[waddr][2*KEY_W-1:KEY_W] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/bhq_cell.sv
module bhq_cell import bhq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [LVL_W-1:0]   cell_lvl,
  input  tok_t               tok_in,
  output tok_t               tok_out,
  input  fetch_t             fetch_in,
  output key_t               fetch_data,
  input  wr_t                back_in,
  output wr_t                back_out,
  output wr_t                ram_wr,
  output logic [ROW_W-1:0]   ram_raddr,
  input  logic [2*KEY_W-1:0] ram_rdata,
  output logic               done
);

  tok_t             tok_r;
  tok_t             tok_out_r;
  tok_t             tok_out_nxt;
  logic             fet_vld_r;
  logic             fet_half_r;
  logic             rc_ok_r;
  logic             lkids_r;
  logic             rkids_r;
  logic             rc_ok_nxt;
  logic             lkids_nxt;
  logic             rkids_nxt;
  logic [CHK_W-1:0] pp_ext;
  logic [CHK_W-1:0] lim_ext;
  key_t             left;
  key_t             right;
  key_t             cur;
  key_t             best;
  logic             path_bit;
  logic             take;
  logic             take_l;
  logic             take_r;
  logic             swap;
  logic             kids;
  wr_t              own_wr;

  // child bounds for the token being read, registered alongside it
  assign pp_ext    = CHK_W'(tok_in.par_pos);
  assign lim_ext   = CHK_W'(tok_in.lim);
  assign rc_ok_nxt = ((pp_ext << 1) + CHK_W'(2)) < lim_ext;
  assign lkids_nxt = ((pp_ext << 2) + CHK_W'(3)) < lim_ext;
  assign rkids_nxt = ((pp_ext << 2) + CHK_W'(5)) < lim_ext;

  assign ram_raddr = tok_in.vld ? tok_in.par_off : fetch_in.row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r      <= '0;
      tok_out_r  <= '0;
      fet_vld_r  <= 1'b0;
    end else begin
      tok_r      <= tok_in;
      tok_out_r  <= tok_out_nxt;
      fet_vld_r  <= fetch_in.en && (fetch_in.lvl == cell_lvl);
    end
  end

  always_ff @(posedge clk) begin
    fet_half_r <= fetch_in.half;
    rc_ok_r    <= rc_ok_nxt;
    lkids_r    <= lkids_nxt;
    rkids_r    <= rkids_nxt;
  end

  assign left     = ram_rdata[KEY_W-1:0];
  assign right    = ram_rdata[2*KEY_W-1:KEY_W];
  assign path_bit = tok_r.path[tok_r.lv_left - LVL_W'(1)];

  always_comb begin
    own_wr      = '0;
    back_out    = '0;
    tok_out_nxt = '0;
    done        = 1'b0;
    cur         = path_bit ? right : left;
    take        = tok_r.shift || key_less(tok_r.key, cur);
    take_l      = key_less(left, tok_r.key);
    best        = take_l ? left : tok_r.key;
    take_r      = rc_ok_r && key_less(right, best);
    swap        = take_l || take_r;
    kids        = take_r ? rkids_r : lkids_r;
    if (tok_r.vld) begin
      unique case (tok_r.op)
        OP_INSERT: begin
          own_wr.row  = tok_r.par_off;
          own_wr.half = path_bit;
          own_wr.data = tok_r.key;
          if (tok_r.lv_left == LVL_W'(1)) begin
            // free slot at the end of the path
            own_wr.en = 1'b1;
            done      = 1'b1;
          end else begin
            // once the key lands, every entry further down the path shifts one level down
            own_wr.en           = take;
            tok_out_nxt         = tok_r;
            tok_out_nxt.shift   = take;
            tok_out_nxt.key     = take ? cur : tok_r.key;
            tok_out_nxt.par_off = ROW_W'({tok_r.par_off, path_bit});
            tok_out_nxt.lv_left = tok_r.lv_left - LVL_W'(1);
          end
        end
        OP_EXTRACT: begin
          back_out.en   = 1'b1;
          back_out.row  = tok_r.par_off >> 1;
          back_out.half = tok_r.par_off[0];
          back_out.data = swap ? (take_r ? right : left) : tok_r.key;
          own_wr.row    = tok_r.par_off;
          own_wr.half   = take_r;
          own_wr.data   = tok_r.key;
          if (!swap) begin
            done = 1'b1;
          end else if (kids) begin
            tok_out_nxt         = tok_r;
            tok_out_nxt.par_pos = POS_W'({tok_r.par_pos, take_r}) + POS_W'(1);
            tok_out_nxt.par_off = ROW_W'({tok_r.par_off, take_r});
          end else begin
            // child is a leaf: drop the key into its slot
            own_wr.en = 1'b1;
            done      = 1'b1;
          end
        end
      endcase
    end
  end

  assign ram_wr     = own_wr.en ? own_wr : back_in;
  assign tok_out    = tok_out_r;
  assign fetch_data = fet_vld_r ? (fet_half_r ? right : left) : '0;

endmodule

// File: hdl/binary_min_heap_queue_core.sv
// Binary min-heap priority queue of signed 32-bit keys, up to CAPACITY entries.
// Input channel (in_valid/in_stall): in_mode selects insert (0) or extract
// minimum (1); in_key_in is the key to insert. Result channel
// (out_valid/out_stall): one item per input item with out_status, the
// extracted key (out_key_out), the root after the operation (out_top_key)
// and the number of keys held (out_entry_count).
// Each heap level below the root is one level unit with its own memory; an
// operation walks down the units, each reading its memory, then comparing
// and writing. The root sits in a register. An insert into a heap of n keys
// ends its walk at level L = floor(log2(n+1)). An extract first fetches the
// last entry, then sifts it down from the root; an extract that leaves one
// key puts the fetched entry straight into the root. Full-queue inserts,
// empty extracts and extracts of the only key skip the level units. One item
// is in work at a time; the next can be accepted once the result of the
// current item is loaded into the output register.
// in_stall is high while an item is in work. A finished item waits in the
// output register while out_stall is high, and the next item is accepted
// meanwhile; its result then waits until the register frees.
// Reset empties the queue; the key memories need no clearing.
module binary_min_heap_queue_core import bhq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_mode,
  input  logic signed [KEY_W-1:0] in_key_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic signed [KEY_W-1:0] out_key_out,
  output logic signed [KEY_W-1:0] out_top_key,
  output logic [CNT_W-1:0]        out_entry_count
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROOT  = 6'b000010,
    S_FETCH = 6'b000100,
    S_FWAIT = 6'b001000,
    S_WAIT  = 6'b010000,
    S_RES   = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  key_t             root_r, root_nxt;
  key_t             key_r, key_nxt;
  key_t             kout_r, kout_nxt;
  status_t          st_r, st_nxt;
  tok_t             tok0_r, tok0_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r;
  key_t             out_key_r;
  key_t             out_top_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             res_load;
  logic             ins_take;
  logic [CNT_W-1:0] t_cur;
  logic [LVL_W-1:0] lvl_cur;
  logic [CNT_W-1:0] off_cur;
  fetch_t           fetch_req;
  key_t             fetch_or;

  tok_t             tok_link [0:NCELL];
  wr_t              back_link [1:NCELL+1];
  key_t             fetch_data [NCELL];
  logic [NCELL-1:0] done_vec;

  assign tok_link[0]         = tok0_r;
  assign back_link[NCELL+1]  = '0;

  for (genvar g = 1; g <= NCELL; g++) begin : g_lvl
    localparam int LV_BASE  = (1 << g) - 1;
    localparam int LV_AVAIL = CAPACITY - LV_BASE;
    localparam int LV_FULL  = 1 << (g - 1);
    localparam int LV_ROWS  = ((LV_AVAIL + 1) / 2 < LV_FULL) ? (LV_AVAIL + 1) / 2 : LV_FULL;
    localparam int LV_AW    = (LV_ROWS > 1) ? $clog2(LV_ROWS) : 1;

    wr_t                ram_wr;
    logic [ROW_W-1:0]   ram_raddr;
    logic [2*KEY_W-1:0] ram_rdata;

    bhq_cell u_lvl (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_lvl   (LVL_W'(g)),
      .tok_in     (tok_link[g-1]),
      .tok_out    (tok_link[g]),
      .fetch_in   (fetch_req),
      .fetch_data (fetch_data[g-1]),
      .back_in    (back_link[g+1]),
      .back_out   (back_link[g]),
      .ram_wr     (ram_wr),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .done       (done_vec[g-1])
    );

    bhq_ram #(
      .DEPTH (LV_ROWS),
      .AW    (LV_AW)
    ) u_ram (
      .clk   (clk),
      .we    ({ram_wr.en & ram_wr.half, ram_wr.en & ~ram_wr.half}),
      .waddr (ram_wr.row[LV_AW-1:0]),
      .wdata (ram_wr.data),
      .raddr (ram_raddr[LV_AW-1:0]),
      .rdata (ram_rdata)
    );
  end

  always_comb begin
    fetch_or = '0;
    for (int i = 0; i < NCELL; i++) begin
      fetch_or = fetch_or | fetch_data[i];
    end
  end

  // slot index of the insert target or of the last entry, and its level
  assign t_cur   = cnt_r + CNT_W'(1);
  assign lvl_cur = lead_one(t_cur);
  assign off_cur = t_cur ^ (CNT_W'(1) << lvl_cur);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    root_nxt      = root_r;
    key_nxt       = key_r;
    kout_nxt      = kout_r;
    st_nxt        = st_r;
    tok0_nxt      = '0;
    fetch_req     = '0;
    out_valid_nxt = out_valid_r && out_stall;
    res_load      = 1'b0;
    ins_take      = key_less(key_r, root_r);
    if (back_link[1].en) root_nxt = back_link[1].data;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt  = in_key_in;
          st_nxt   = ST_DONE;
          kout_nxt = '0;
          priority if (op_t'(in_mode) == OP_INSERT) begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              st_nxt    = ST_FULL;
              state_nxt = S_RES;
            end else begin
              state_nxt = S_ROOT;
            end
          end else if (cnt_r == '0) begin
            st_nxt    = ST_EMPTY;
            kout_nxt  = KEY_NONE;
            state_nxt = S_RES;
          end else begin
            kout_nxt  = root_r;
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = (cnt_r == CNT_W'(1)) ? S_RES : S_FETCH;
          end
        end
      end
      S_ROOT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == '0) begin
          root_nxt  = key_r;
          state_nxt = S_RES;
        end else begin
          if (ins_take) root_nxt = key_r;
          tok0_nxt.vld     = 1'b1;
          tok0_nxt.op      = OP_INSERT;
          tok0_nxt.shift   = ins_take;
          tok0_nxt.key     = ins_take ? root_r : key_r;
          tok0_nxt.path    = t_cur;
          tok0_nxt.lv_left = lvl_cur;
          tok0_nxt.lim     = t_cur;
          state_nxt        = S_WAIT;
        end
      end
      S_FETCH: begin
        fetch_req.en   = 1'b1;
        fetch_req.lvl  = lvl_cur;
        fetch_req.row  = off_cur[ROW_W:1];
        fetch_req.half = off_cur[0];
        state_nxt      = S_FWAIT;
      end
      S_FWAIT: begin
        if (cnt_r == CNT_W'(1)) begin
          root_nxt  = fetch_or;
          state_nxt = S_RES;
        end else begin
          // sift the former last entry down from the root
          tok0_nxt.vld = 1'b1;
          tok0_nxt.op  = OP_EXTRACT;
          tok0_nxt.key = fetch_or;
          tok0_nxt.lim = cnt_r;
          state_nxt    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (|done_vec) state_nxt = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || !out_stall) begin
          res_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      tok0_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tok0_r      <= tok0_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    root_r <= root_nxt;
    key_r  <= key_nxt;
    kout_r <= kout_nxt;
    st_r   <= st_nxt;
    if (res_load) begin
      out_status_r <= st_r;
      out_key_r    <= kout_r;
      out_top_r    <= (cnt_r != '0) ? root_r : '0;
      out_cnt_r    <= cnt_r;
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_key_out     = out_key_r;
  assign out_top_key     = out_top_r;
  assign out_entry_count = out_cnt_r;

  a_last_lvl_no_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    !tok_link[NCELL].vld)
    else $error("token passed beyond the deepest level");

  a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(done_vec))
    else $error("more than one level finished in a cycle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (|done_vec) |-> (state_r == S_WAIT))
    else $error("level finished outside a walk");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_entry_count == '0))
    else $error("empty status with entries held");

endmodule

// File: dv/tb_binary_min_heap_queue_core.sv
module tb_binary_min_heap_queue_core;
  import bhq_pkg::*;

  localparam int   HOLD_CYCLES    = 300;
  localparam int   WATCHDOG_LIMIT = 4000;
  localparam int   DRAIN_CYCLES   = 40;
  localparam int   IDLE_PCT       = 28;
  localparam key_t KEY_MIN        = {1'b1, {(KEY_W-1){1'b0}}};
  localparam key_t KEY_MAX        = ~KEY_MIN;

  typedef struct packed {
    op_t  op;
    key_t key;
  } heap_req_t;

  typedef struct packed {
    status_t          status;
    key_t             key_out;
    key_t             top_key;
    logic [CNT_W-1:0] count;
  } heap_result_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_mode   = 1'b0;
  key_t in_key_in = '0;
  logic out_stall = 1'b0;

  logic             in_stall;
  logic             out_valid;
  logic [1:0]       out_status;
  key_t             out_key_out;
  key_t             out_top_key;
  logic [CNT_W-1:0] out_entry_count;

  // expected heap contents, mirrored in software
  key_t        heap_keys [CAPACITY];
  int unsigned heap_fill = 0;

  heap_req_t    pending_q[$];
  heap_result_t due_results[$];
  heap_req_t    next_req;
  heap_result_t cur_due;

  int unsigned plan_fill    = 0;
  int unsigned items_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned err_count    = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned quiet_cycles = 0;

  int unsigned n_insert  = 0;
  int unsigned n_dropped = 0;
  int unsigned n_extract = 0;
  int unsigned n_empty   = 0;
  int unsigned peak_fill = 0;

  binary_min_heap_queue_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_key_in       (in_key_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_key_out     (out_key_out),
    .out_top_key     (out_top_key),
    .out_entry_count (out_entry_count)
  );

  always #4 clk = ~clk;

  // apply one operation to the mirrored heap and return the expected result
  function automatic heap_result_t run_heap_op(input op_t op, input key_t key);
    heap_result_t res;
    int unsigned  pos;
    int unsigned  up;
    int unsigned  lc;
    int unsigned  rc;
    int unsigned  best;
    key_t         tmp;
    logic         moving;
    res.status  = ST_DONE;
    res.key_out = '0;
    if (op == OP_INSERT) begin
      n_insert++;
      if (heap_fill >= CAPACITY) begin
        res.status = ST_FULL;
        n_dropped++;
      end else begin
        pos = heap_fill;
        heap_keys[pos] = key;
        moving = 1'b1;
        while (moving && pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_keys[pos] < heap_keys[up]) begin
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[up];
            heap_keys[up] = tmp;
            pos = up;
          end else begin
            moving = 1'b0;
          end
        end
        heap_fill++;
        if (heap_fill > peak_fill) peak_fill = heap_fill;
      end
    end else begin
      n_extract++;
      if (heap_fill == 0) begin
        res.status  = ST_EMPTY;
        res.key_out = KEY_NONE;
        n_empty++;
      end else begin
        res.key_out = heap_keys[0];
        heap_keys[0] = heap_keys[heap_fill - 1];
        heap_fill--;
        pos = 0;
        moving = 1'b1;
        // left child first, right child only on strictly less
        while (moving && 2 * pos + 1 < heap_fill) begin
          lc = 2 * pos + 1;
          rc = lc + 1;
          best = pos;
          if (heap_keys[lc] < heap_keys[best]) best = lc;
          if (rc < heap_fill && heap_keys[rc] < heap_keys[best]) best = rc;
          if (best == pos) begin
            moving = 1'b0;
          end else begin
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[best];
            heap_keys[best] = tmp;
            pos = best;
          end
        end
      end
    end
    res.top_key = (heap_fill > 0) ? heap_keys[0] : '0;
    res.count   = CNT_W'(heap_fill);
    return res;
  endfunction

  function automatic key_t pick_key();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return key_t'($urandom);
    // narrow range: plenty of equal keys
    if (sel < 78) return key_t'(int'($urandom_range(16)) - 8);
    if (sel < 84) return KEY_MIN + key_t'($urandom_range(3));
    if (sel < 90) return KEY_MAX - key_t'($urandom_range(3));
    if (sel < 95) return KEY_NONE;
    return '0;
  endfunction

  // queue one item and track the fill level it leaves behind
  task automatic queue_req(input op_t op, input key_t key);
    heap_req_t req;
    req.op  = op;
    req.key = key;
    pending_q.push_back(req);
    if (op == OP_INSERT) begin
      if (plan_fill < CAPACITY) plan_fill++;
    end else if (plan_fill > 0) begin
      plan_fill--;
    end
  endtask

  function automatic op_t pick_op(input int unsigned insert_pct);
    return ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40) $display("MISMATCH at result %0d: %s", results_seen, what);
  endtask

  // driver: predict on accept, then offer the next item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(run_heap_op(op_t'(in_mode), in_key_in));
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 &&
            ((items_taken >= 600 && items_taken < 900) || $urandom_range(99) >= IDLE_PCT)) begin
          next_req = pending_q.pop_front();
          in_valid  <= 1'b1;
          in_mode   <= next_req.op;
          in_key_in <= next_req.key;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result against the oldest expectation, drive stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing due: status %0d key_out %0d",
                                    out_status, out_key_out));
        end else begin
          cur_due = due_results.pop_front();
          if (out_status !== cur_due.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, cur_due.status));
          if (out_key_out !== cur_due.key_out)
            report_mismatch($sformatf("key_out %0d, want %0d", out_key_out, cur_due.key_out));
          if (out_top_key !== cur_due.top_key)
            report_mismatch($sformatf("top_key %0d, want %0d", out_top_key, cur_due.top_key));
          if (out_entry_count !== cur_due.count)
            report_mismatch($sformatf("entry_count %0d, want %0d",
                                      out_entry_count, cur_due.count));
        end
      end
      // one long hold so the block backs up and stalls its input
      if (!hold_done && results_seen >= 150) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(results_seen >= 600 && results_seen < 900) &&
                     ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog: nothing accepted on either side for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_binary_min_heap_queue_core: done, errors");
    $finish;
  end

  initial begin
    // directed: empty extract, extremes, equal keys, full drain
    queue_req(OP_EXTRACT, KEY_MAX);
    queue_req(OP_INSERT, '0);
    queue_req(OP_INSERT, KEY_MAX);
    queue_req(OP_INSERT, KEY_MIN);
    queue_req(OP_INSERT, KEY_NONE);
    queue_req(OP_INSERT, key_t'(5));
    queue_req(OP_INSERT, key_t'(5));
    queue_req(OP_INSERT, key_t'(5));
    repeat (8) queue_req(OP_EXTRACT, key_t'($urandom));
    queue_req(OP_EXTRACT, KEY_MIN);
    queue_req(OP_INSERT, KEY_MIN);
    queue_req(OP_EXTRACT, '0);
    queue_req(OP_INSERT, KEY_MAX);
    queue_req(OP_INSERT, KEY_MAX);
    queue_req(OP_EXTRACT, KEY_NONE);
    queue_req(OP_EXTRACT, KEY_NONE);

    // random: mixed, fill to capacity, hover at full, then a partial drain
    repeat (40) queue_req(pick_op(55), pick_key());
    while (plan_fill < CAPACITY) queue_req(pick_op(98), pick_key());
    repeat (40) queue_req(pick_op(75), pick_key());
    repeat (60) queue_req(pick_op(10), pick_key());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d inserts (%0d dropped at capacity), %0d extracts (%0d on empty)",
             n_insert, n_dropped, n_extract, n_empty);
    $display("peak fill %0d of %0d, %0d results checked, %0d mismatches",
             peak_fill, CAPACITY, results_seen, err_count);
    if (err_count == 0) begin
      $display("tb_binary_min_heap_queue_core: done, clean");
    end else begin
      $display("tb_binary_min_heap_queue_core: done, errors");
    end
    $finish;
  end

endmodule
